>>> hw/rtl/qyaw_pkg.sv
// Package for the quaternion yaw heading block: constants, shared types and
// the arctangent table of the CORDIC unit. Depends on nothing.
package qyaw_pkg;

   // Input component precision and CORDIC iteration count.
   localparam int QUAT_BITS   = 16;
   localparam int ANGLE_STEPS = 16;

   // Port field widths.
   localparam int FIELD_W = 16;
   localparam int DEG_W   = 9;
   localparam int TOTAL_W = 32;
   localparam int THR_W   = 9;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(300);

   // Internal widths derived from the component precision.
   localparam int PROD_W     = 2 * QUAT_BITS;
   localparam int NUM_W      = 2 * QUAT_BITS + 2;
   localparam int SQ_W       = 2 * QUAT_BITS + 1;
   localparam int VEC_W      = 2 * QUAT_BITS + 6;
   localparam int ANGLE_FRAC = 16;
   localparam int ANG_W      = ANGLE_FRAC + 10;
   localparam int SDEG_W     = 11;
   localparam int SUM_W      = TOTAL_W + 2;
   localparam int ITER_W     = $clog2(ANGLE_STEPS);
   localparam int TAB_IDX_W  = 5;
   localparam int TAB_W      = 22;
   localparam int MUL_STEPS  = 4;

   // One in Q(2*(QUAT_BITS-1)) at the vector width.
   localparam logic signed [VEC_W-1:0] UNIT_VEC = VEC_W'(1) << (2 * (QUAT_BITS - 1));

   // Fixed angles in units of 2^-16 degree.
   localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90) << ANGLE_FRAC;
   localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180) << ANGLE_FRAC;

   localparam logic signed [SDEG_W-1:0] FULL_TURN = SDEG_W'(360);

   localparam logic signed [SUM_W-1:0] TOTAL_MAX = SUM_W'(33'sh0_7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] TOTAL_MIN = -SUM_W'(33'sh0_8000_0000);

   // Operand pair used by the shared multiplier.
   typedef enum logic [1:0] {
      MUL_WZ = 2'd0,
      MUL_XY = 2'd1,
      MUL_YY = 2'd2,
      MUL_ZZ = 2'd3
   } mul_sel_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_INIT,
      ST_ITER,
      ST_DEG,
      ST_COMMIT
   } fsm_state_type;

   // Controls from the sequencer to the datapath.
   typedef struct packed {
      logic              req_ready;
      logic              take;
      logic              mul_en;
      mul_sel_type       mul_sel;
      logic              init_en;
      logic              iter_en;
      logic [ITER_W-1:0] iter_idx;
      logic              deg_en;
      logic              commit;
   } ctl_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic num_zero;
      logic out_busy;
   } sts_type;

   // atan(2^-i) in degrees times 65536, rounded.
   function automatic logic [TAB_W-1:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
      logic [TAB_W-1:0] val;
      case (idx)
         5'd0:    val = TAB_W'(2949120);
         5'd1:    val = TAB_W'(1740967);
         5'd2:    val = TAB_W'(919879);
         5'd3:    val = TAB_W'(466945);
         5'd4:    val = TAB_W'(234379);
         5'd5:    val = TAB_W'(117304);
         5'd6:    val = TAB_W'(58666);
         5'd7:    val = TAB_W'(29335);
         5'd8:    val = TAB_W'(14668);
         5'd9:    val = TAB_W'(7334);
         5'd10:   val = TAB_W'(3667);
         5'd11:   val = TAB_W'(1833);
         5'd12:   val = TAB_W'(917);
         5'd13:   val = TAB_W'(458);
         5'd14:   val = TAB_W'(229);
         5'd15:   val = TAB_W'(115);
         5'd16:   val = TAB_W'(57);
         5'd17:   val = TAB_W'(29);
         5'd18:   val = TAB_W'(14);
         5'd19:   val = TAB_W'(7);
         5'd20:   val = TAB_W'(4);
         5'd21:   val = TAB_W'(2);
         5'd22:   val = TAB_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> hw/rtl/qyaw_if.sv
// Valid/ready channel interfaces for the quaternion request and heading response.
// Depends on qyaw_pkg for the field widths.
interface qyaw_req_if import qyaw_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] quat_x;
   logic signed [FIELD_W-1:0] quat_y;
   logic signed [FIELD_W-1:0] quat_z;
   logic signed [FIELD_W-1:0] quat_w;

   modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qyaw_rsp_if import qyaw_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic        [DEG_W-1:0]   heading_deg;
   logic signed [TOTAL_W-1:0] total_heading;

   modport source (output valid, heading_deg, total_heading, input ready);
   modport sink   (input valid, heading_deg, total_heading, output ready);
endinterface

>>> hw/rtl/quaternion_yaw_heading_unwrap.sv
// Top level of the quaternion yaw heading block with unwrapped running total.
// Depends on qyaw_pkg, qyaw_if, qyaw_ctrl and qyaw_datapath.
//
// Usage:
// The req_bus channel carries one orientation quaternion (x, y, z, w), each a
// signed Q1.15 value. The rsp_bus channel returns the yaw in whole degrees
// (0 to 359) and the accumulated, unwrapped heading change, which saturates at
// the signed 32-bit limits. Both channels move a transaction when valid and
// ready are high at a rising clock edge. csr_wr_en writes csr_wr_data into the
// wrap threshold; write it only while the block is idle.
// After a transaction is accepted, the block runs the products w*z, x*y, y*y
// and z*z on the shared multiplier, a setup step, sixteen CORDIC iterations
// on one shift-add unit, then conversion and accumulation. A zero numerator
// skips the iterations. The block takes no new transaction until the previous
// one has been loaded into the output register.
// Reset clears the running total and the last heading, marks the next sample
// as the first one and loads a threshold of 300 degrees.
// A stalled receiver holds the result in the output register; the block still
// takes and processes the next transaction and waits before its final step
// until the output register is free.
module quaternion_yaw_heading_unwrap import qyaw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   qyaw_req_if.sink         req_bus,
   qyaw_rsp_if.source       rsp_bus,
   input  logic             csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data
);

   ctl_type ctl;
   sts_type sts;

   // Sequencer.
   qyaw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .sts       (sts),
      .ctl       (ctl)
   );

   // Arithmetic and state.
   qyaw_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_quat_x        (req_bus.quat_x),
      .req_quat_y        (req_bus.quat_y),
      .req_quat_z        (req_bus.quat_z),
      .req_quat_w        (req_bus.quat_w),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_heading_deg   (rsp_bus.heading_deg),
      .rsp_total_heading (rsp_bus.total_heading)
   );

   assign req_bus.ready = ctl.req_ready;

endmodule

>>> hw/rtl/qyaw_ctrl.sv
// Sequencer of the quaternion yaw block: steps the shared multiplier and
// the CORDIC unit through one transaction. Depends on qyaw_pkg.
module qyaw_ctrl import qyaw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  sts_type sts,
   output ctl_type ctl
);

   fsm_state_type     state_ff, state_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              mul_last;
   logic              iter_last;

   assign mul_last  = (cnt_ff == ITER_W'(MUL_STEPS - 1));
   assign iter_last = (cnt_ff == ITER_W'(ANGLE_STEPS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MUL;
         ST_MUL:    if (mul_last) state_in = ST_INIT;
         ST_INIT:   state_in = sts.num_zero ? ST_DEG : ST_ITER;
         ST_ITER:   if (iter_last) state_in = ST_DEG;
         ST_DEG:    state_in = ST_COMMIT;
         ST_COMMIT: if (!sts.out_busy) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Step counter, shared by the multiply and iteration phases.
   always_comb begin
      if (state_in != state_ff) begin
         cnt_in = '0;
      end else if (state_ff == ST_MUL || state_ff == ST_ITER) begin
         cnt_in = cnt_ff + ITER_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Outputs. The request channel stays closed while reset is high.
   always_comb begin
      ctl          = '0;
      ctl.mul_sel  = mul_sel_type'(cnt_ff[1:0]);
      ctl.iter_idx = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            ctl.req_ready = !reset;
            ctl.take      = req_valid && !reset;
         end
         ST_MUL:    ctl.mul_en  = 1'b1;
         ST_INIT:   ctl.init_en = 1'b1;
         ST_ITER:   ctl.iter_en = 1'b1;
         ST_DEG:    ctl.deg_en  = 1'b1;
         ST_COMMIT: ctl.commit  = !sts.out_busy;
         default:   ctl.req_ready = 1'b0;
      endcase
   end

endmodule

>>> hw/rtl/qyaw_datapath.sv
// Datapath of the quaternion yaw block: shared multiplier, CORDIC vectoring
// unit, degree conversion, unwrap accumulator and output register. Depends on qyaw_pkg.
module qyaw_datapath import qyaw_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_type                   ctl,
   output sts_type                   sts,
   input  logic signed [FIELD_W-1:0] req_quat_x,
   input  logic signed [FIELD_W-1:0] req_quat_y,
   input  logic signed [FIELD_W-1:0] req_quat_z,
   input  logic signed [FIELD_W-1:0] req_quat_w,
   input  logic                      csr_wr_en,
   input  logic        [THR_W-1:0]   csr_wr_data,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic        [DEG_W-1:0]   rsp_heading_deg,
   output logic signed [TOTAL_W-1:0] rsp_total_heading
);

   // Captured quaternion.
   logic signed [QUAT_BITS-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [QUAT_BITS-1:0] qx_in, qy_in, qz_in, qw_in;

   // Multiply-accumulate results.
   logic signed [QUAT_BITS-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0]    prod;
   logic signed [NUM_W-1:0]     num_acc_ff, num_acc_in;
   logic signed [SQ_W-1:0]      sq_acc_ff, sq_acc_in;

   // CORDIC state.
   logic signed [VEC_W-1:0] num_v, den_v;
   logic signed [VEC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [VEC_W-1:0] xs, ys;
   logic signed [ANG_W-1:0] ang_ff, ang_in;
   logic signed [ANG_W-1:0] tab_val;

   // Degree conversion.
   logic signed [ANG_W-1:0]  ang_mag;
   logic [SDEG_W-2:0]        whole;
   logic signed [SDEG_W-1:0] sdeg;
   logic [DEG_W-1:0]         heading_ff, heading_in;

   // Unwrap and total.
   logic [THR_W-1:0]          thr_ff, thr_in;
   logic                      first_ff, first_in;
   logic [DEG_W-1:0]          last_ff, last_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic signed [SDEG_W-1:0]  diff, thr_s;
   logic signed [SUM_W-1:0]   sum;
   logic signed [TOTAL_W-1:0] total_sat;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DEG_W-1:0]          rsp_heading_ff, rsp_heading_in;
   logic signed [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   // Capture the components of an accepted transaction.
   always_comb begin
      qx_in = qx_ff;
      qy_in = qy_ff;
      qz_in = qz_ff;
      qw_in = qw_ff;
      if (ctl.take) begin
         qx_in = QUAT_BITS'(req_quat_x);
         qy_in = QUAT_BITS'(req_quat_y);
         qz_in = QUAT_BITS'(req_quat_z);
         qw_in = QUAT_BITS'(req_quat_w);
      end
   end

   // Shared multiplier: w*z, x*y, y*y and z*z in turn.
   always_comb begin
      case (ctl.mul_sel)
         MUL_WZ:  begin mul_a = qw_ff; mul_b = qz_ff; end
         MUL_XY:  begin mul_a = qx_ff; mul_b = qy_ff; end
         MUL_YY:  begin mul_a = qy_ff; mul_b = qy_ff; end
         MUL_ZZ:  begin mul_a = qz_ff; mul_b = qz_ff; end
         default: begin mul_a = qz_ff; mul_b = qz_ff; end
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      num_acc_in = num_acc_ff;
      sq_acc_in  = sq_acc_ff;
      if (ctl.mul_en) begin
         case (ctl.mul_sel)
            MUL_WZ:  num_acc_in = NUM_W'(prod);
            MUL_XY:  num_acc_in = num_acc_ff + NUM_W'(prod);
            MUL_YY:  sq_acc_in  = SQ_W'(prod);
            MUL_ZZ:  sq_acc_in  = sq_acc_ff + SQ_W'(prod);
            default: sq_acc_in  = sq_acc_ff;
         endcase
      end
   end

   // Numerator 2(wz+xy) and denominator 1-2(yy+zz).
   assign num_v = VEC_W'(num_acc_ff) <<< 1;
   assign den_v = UNIT_VEC - (VEC_W'(sq_acc_ff) <<< 1);

   assign sts.num_zero = (num_acc_ff == '0);
   assign sts.out_busy = rsp_valid_ff && !rsp_ready;

   // CORDIC: quadrant fold at init, then one shift-add rotation per cycle.
   assign xs      = x_ff >>> ctl.iter_idx;
   assign ys      = y_ff >>> ctl.iter_idx;
   assign tab_val = ANG_W'(atan_deg(TAB_IDX_W'(ctl.iter_idx)));

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      ang_in = ang_ff;
      if (ctl.init_en) begin
         if (num_v == '0) begin
            ang_in = den_v[VEC_W-1] ? ANG_180 : '0;
         end else if (den_v[VEC_W-1]) begin
            if (!num_v[VEC_W-1]) begin
               x_in   = num_v;
               y_in   = -den_v;
               ang_in = ANG_90;
            end else begin
               x_in   = -num_v;
               y_in   = den_v;
               ang_in = -ANG_90;
            end
         end else begin
            x_in   = den_v;
            y_in   = num_v;
            ang_in = '0;
         end
      end else if (ctl.iter_en) begin
         if (!y_ff[VEC_W-1]) begin
            x_in   = x_ff + ys;
            y_in   = y_ff - xs;
            ang_in = ang_ff + tab_val;
         end else begin
            x_in   = x_ff - ys;
            y_in   = y_ff + xs;
            ang_in = ang_ff - tab_val;
         end
      end
   end

   // Truncate toward zero to whole degrees and fold into 0..359.
   assign ang_mag = ang_ff[ANG_W-1] ? -ang_ff : ang_ff;
   assign whole   = ang_mag[ANG_W-1:ANGLE_FRAC];

   always_comb begin
      sdeg = $signed({1'b0, whole});
      if (ang_ff[ANG_W-1]) begin
         sdeg = -sdeg;
      end
      if (sdeg < 0) begin
         sdeg = sdeg + FULL_TURN;
      end
      if (sdeg >= FULL_TURN) begin
         sdeg = sdeg - FULL_TURN;
      end
      if (sdeg < 0) begin
         sdeg = '0;
      end
      heading_in = ctl.deg_en ? sdeg[DEG_W-1:0] : heading_ff;
   end

   // Unwrapped difference and saturating total.
   assign thr_s = $signed({2'b00, thr_ff});

   always_comb begin
      diff = $signed({2'b00, last_ff}) - $signed({2'b00, heading_ff});
      if (diff > thr_s) begin
         diff = diff - FULL_TURN;
      end else if (diff < -thr_s) begin
         diff = diff + FULL_TURN;
      end
      sum = SUM_W'(total_ff) + SUM_W'(diff);
      if (sum > TOTAL_MAX) begin
         total_sat = TOTAL_MAX[TOTAL_W-1:0];
      end else if (sum < TOTAL_MIN) begin
         total_sat = TOTAL_MIN[TOTAL_W-1:0];
      end else begin
         total_sat = sum[TOTAL_W-1:0];
      end
   end

   always_comb begin
      first_in = first_ff;
      last_in  = last_ff;
      total_in = total_ff;
      if (ctl.commit) begin
         first_in = 1'b0;
         last_in  = heading_ff;
         if (!first_ff) begin
            total_in = total_sat;
         end
      end
   end

   assign thr_in = csr_wr_en ? csr_wr_data : thr_ff;

   // Output register, loaded when the previous result has been taken.
   always_comb begin
      rsp_heading_in = rsp_heading_ff;
      rsp_total_in   = rsp_total_ff;
      if (ctl.commit) begin
         rsp_valid_in   = 1'b1;
         rsp_heading_in = heading_ff;
         rsp_total_in   = total_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_RESET;
         first_ff     <= 1'b1;
         last_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      qx_ff          <= qx_in;
      qy_ff          <= qy_in;
      qz_ff          <= qz_in;
      qw_ff          <= qw_in;
      num_acc_ff     <= num_acc_in;
      sq_acc_ff      <= sq_acc_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      ang_ff         <= ang_in;
      heading_ff     <= heading_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heading_deg   = rsp_heading_ff;
   assign rsp_total_heading = rsp_total_ff;

endmodule

>>> tb/sv/qyaw_checker.sv
`timescale 1ns / 100ps
// Checker for the quaternion yaw heading block. It watches both channels and the
// threshold port, predicts each response and compares it field by field.
// Depends on qyaw_pkg for widths and on qyaw_if for the channel interfaces.
module qyaw_checker import qyaw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   qyaw_req_if              req_bus,
   qyaw_rsp_if              rsp_bus,
   input  logic             csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data,
   output int               fail_count,
   output int               pending
);

   typedef struct {
      logic        [DEG_W-1:0]   heading_deg;
      logic signed [TOTAL_W-1:0] total_heading;
   } heading_result_type;

   // Rotation angles atan(2^-i) in degrees, scaled by 2^16 and rounded.
   localparam longint ROTATION_STEP [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };
   localparam longint DEG_TURN = 360;
   localparam longint TOTAL_HI = (longint'(1) << 31) - 1;
   localparam longint TOTAL_LO = -(longint'(1) << 31);

   // Predicted state of the block.
   logic             awaiting_first;
   longint           prev_heading;
   longint           accumulated;
   logic [THR_W-1:0] wrap_limit;

   heading_result_type expected_headings[$];

   // Works out the response to one quaternion and advances the predicted state.
   function automatic heading_result_type predict_heading(input longint qx, input longint qy,
                                                          input longint qz, input longint qw);
      longint num, den, vx, vy, ang, t, sx, sy, deg, diff;
      heading_result_type res;
      num = 2 * (qw * qz + qx * qy);
      den = (longint'(1) << (2 * (QUAT_BITS - 1))) - 2 * (qy * qy + qz * qz);
      vx  = den;
      vy  = num;
      ang = 0;
      if (vy == 0) begin
         // A zero numerator lands exactly on 0 or 180 degrees.
         ang = (vx < 0) ? (longint'(180) << ANGLE_FRAC) : longint'(0);
      end else begin
         // Bring the vector into the right half plane first.
         if (vx < 0) begin
            t = vx;
            if (vy >= 0) begin
               vx  = vy;
               vy  = -t;
               ang = longint'(90) << ANGLE_FRAC;
            end else begin
               vx  = -vy;
               vy  = t;
               ang = -(longint'(90) << ANGLE_FRAC);
            end
         end
         for (int i = 0; i < ANGLE_STEPS && i < 24; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0) begin
               vx  = vx + sy;
               vy  = vy - sx;
               ang = ang + ROTATION_STEP[i];
            end else begin
               vx  = vx - sy;
               vy  = vy + sx;
               ang = ang - ROTATION_STEP[i];
            end
         end
      end

      // Truncate toward zero to whole degrees and fold into 0..359.
      if (ang < 0) deg = -((-ang) >>> ANGLE_FRAC);
      else deg = ang >>> ANGLE_FRAC;
      if (deg < 0) deg = deg + DEG_TURN;
      if (deg >= DEG_TURN) deg = deg - DEG_TURN;
      if (deg < 0) deg = 0;

      // Unwrap the change against the previous heading and accumulate it.
      if (awaiting_first) begin
         awaiting_first = 1'b0;
      end else begin
         diff = prev_heading - deg;
         if (diff > longint'(wrap_limit)) diff = diff - DEG_TURN;
         else if (diff < -longint'(wrap_limit)) diff = diff + DEG_TURN;
         accumulated = accumulated + diff;
         if (accumulated > TOTAL_HI) accumulated = TOTAL_HI;
         if (accumulated < TOTAL_LO) accumulated = TOTAL_LO;
      end
      prev_heading = deg;

      res.heading_deg   = DEG_W'(deg);
      res.total_heading = TOTAL_W'(accumulated);
      return res;
   endfunction

   // Track the threshold, compare each response and queue each prediction.
   always @(posedge clock) begin
      heading_result_type want;
      if (reset) begin
         expected_headings.delete();
         awaiting_first = 1'b1;
         prev_heading   = 0;
         accumulated    = 0;
         wrap_limit     = THR_RESET;
         fail_count     = 0;
         pending        = 0;
      end else begin
         if (csr_wr_en) wrap_limit = csr_wr_data;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_headings.size() == 0) begin
               $error("response transaction with none expected: heading_deg %0d, total_heading %0d",
                      rsp_bus.heading_deg, rsp_bus.total_heading);
               fail_count++;
            end else begin
               want = expected_headings.pop_front();
               if (rsp_bus.heading_deg !== want.heading_deg) begin
                  $error("heading_deg mismatch: expected %0d, actual %0d",
                         want.heading_deg, rsp_bus.heading_deg);
                  fail_count++;
               end
               if (rsp_bus.total_heading !== want.total_heading) begin
                  $error("total_heading mismatch: expected %0d, actual %0d",
                         want.total_heading, rsp_bus.total_heading);
                  fail_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_headings.push_back(predict_heading(req_bus.quat_x, req_bus.quat_y,
                                                        req_bus.quat_z, req_bus.quat_w));
         end
         pending = expected_headings.size();
      end
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for quaternion_yaw_heading_unwrap: clock, reset, stimulus
// on the request channel, response back-pressure, threshold writes and verdict.
// Depends on qyaw_pkg, qyaw_if, the block itself and qyaw_checker.
module testbench import qyaw_pkg::*; ();

   localparam int STALL_PCT        = 24;
   localparam int RANDOM_PER_PHASE = 272;
   localparam int DRAIN_CYCLES     = 30;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam real PI              = 3.14159265358979;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic [THR_W-1:0] csr_wr_data = '0;
   logic             calm        = 1'b0;
   int               fail_count;
   int               pending;
   int               quiet_cycles = 0;
   real              yaw_walk     = 0.0;

   qyaw_req_if req_bus ();
   qyaw_rsp_if rsp_bus ();

   quaternion_yaw_heading_unwrap i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   qyaw_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always #2 clock = ~clock;

   // Response back-pressure, none while the run is in a calm stretch.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= calm || ($urandom_range(99) >= STALL_PCT);
      end
   end

   // End the run when no transaction has moved for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** quaternion_yaw_heading_unwrap: FAILED **");
         $finish;
      end
   end

   // Offer one quaternion, after a random gap, and hold it until it is taken.
   task automatic send_quat(input logic signed [FIELD_W-1:0] qx,
                            input logic signed [FIELD_W-1:0] qy,
                            input logic signed [FIELD_W-1:0] qz,
                            input logic signed [FIELD_W-1:0] qw);
      while (!calm && $urandom_range(99) < STALL_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.quat_x <= qx;
      req_bus.quat_y <= qy;
      req_bus.quat_z <= qz;
      req_bus.quat_w <= qw;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // A yaw rotation in degrees, with an optional random tilt in x and y.
   task automatic send_yaw(input real yaw_deg, input int tilt);
      real half;
      logic signed [FIELD_W-1:0] qx, qy;
      half = yaw_deg * PI / 360.0;
      qx   = FIELD_W'(int'($urandom_range(2 * tilt)) - tilt);
      qy   = FIELD_W'(int'($urandom_range(2 * tilt)) - tilt);
      send_quat(qx, qy, FIELD_W'(int'(32767.0 * $sin(half))),
                FIELD_W'(int'(32767.0 * $cos(half))));
   endtask

   // Let every response come home and the block settle.
   task automatic drain;
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly heading walks with random steps, plus raw and zero-numerator noise.
   task automatic run_random(input int count);
      int pick;
      int step;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            send_quat(FIELD_W'($urandom()), FIELD_W'($urandom()),
                      FIELD_W'($urandom()), FIELD_W'($urandom()));
         end else if (pick < 25) begin
            case ($urandom_range(2))
               0:       send_quat('0, '0, '0, FIELD_W'($urandom()));
               1:       send_quat('0, '0, FIELD_W'($urandom()), '0);
               default: send_quat(FIELD_W'($urandom()), '0, '0, '0);
            endcase
         end else begin
            pick = $urandom_range(99);
            if (pick < 55) step = int'($urandom_range(80)) - 40;
            else if (pick < 85) step = int'($urandom_range(720)) - 360;
            else step = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(190, 170));
            yaw_walk = yaw_walk + step + $urandom_range(999) / 1000.0;
            if (yaw_walk > 3600.0 || yaw_walk < -3600.0) yaw_walk = 0.0;
            send_yaw(yaw_walk, $urandom_range(3) == 0 ? int'($urandom_range(3000)) : 0);
         end
      end
   endtask

   initial begin
      logic [THR_W-1:0] thr_plan [5];
      req_bus.valid  = 1'b0;
      req_bus.quat_x = '0;
      req_bus.quat_y = '0;
      req_bus.quat_z = '0;
      req_bus.quat_w = '0;
      thr_plan = '{9'd180, 9'd359, 9'd0, 9'd511, THR_W'($urandom_range(359, 180))};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part under the reset threshold; the all-zero vector comes first.
      send_quat('0, '0, '0, '0);
      send_quat('0, '0, '0, 16'sh7FFF);
      send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
      send_quat(16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000);
      send_quat(-16'sh8000, '0, '0, '0);
      send_quat('0, -16'sh8000, '0, '0);
      send_quat('0, '0, 16'sh7FFF, '0);
      send_quat('0, '0, -16'sh8000, '0);
      send_quat('0, '0, 16'sh7FFF, 16'sh0001);
      send_quat('0, '0, 16'sh7FFF, -16'sh0001);
      send_yaw(90.0, 0);
      send_yaw(-90.0, 0);
      send_yaw(-179.6, 0);
      send_yaw(179.6, 0);
      // Small steps across zero in both directions.
      send_yaw(2.5, 0);
      send_yaw(-1.5, 0);
      send_yaw(1.5, 0);
      send_yaw(0.2, 0);
      // Large jumps below and above the reset threshold.
      send_yaw(250.5, 0);
      send_yaw(10.5, 0);
      send_yaw(340.5, 0);
      send_yaw(5.5, 400);

      run_random(RANDOM_PER_PHASE);
      for (int p = 0; p < 5; p++) begin
         write_threshold(thr_plan[p]);
         calm = (p == 1);
         run_random(RANDOM_PER_PHASE);
      end
      calm = 1'b0;

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("** quaternion_yaw_heading_unwrap: PASSED **");
      end else begin
         $display("** quaternion_yaw_heading_unwrap: FAILED **");
      end
      $finish;
   end

endmodule
